@@ hw/rtl/mmms_pkg.sv @@
// Shared widths and types for the mean / median / mode statistics unit.
package mmms_pkg;

  localparam int IN_VALUE_W   = 16;
  localparam int IN_TDATA_W   = 16;
  localparam int COUNT_W      = 8;
  localparam int MEAN_W       = 24;
  localparam int MEDIAN_W     = 17;
  localparam int MODE_W       = 16;
  localparam int OUT_USED_W   = COUNT_W + MEAN_W + MEDIAN_W + MODE_W + 2;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  typedef struct packed {
    logic insert;
    logic shift;
  } mmms_cell_ctl_t;

endpackage

@@ hw/rtl/mmms_cell.sv @@
// One cell of the sorted sample row: insert by shifting up, unload by shifting down.
module mmms_cell #(
  parameter int VALUE_BITS = 16,
  parameter int CNT_BITS   = 8,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  mmms_pkg::mmms_cell_ctl_t ctl,
  input  logic [VALUE_BITS-1:0] din,
  input  logic [CNT_BITS-1:0]   count,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic                  left_gt,
  input  logic [VALUE_BITS-1:0] right_val,
  output logic [VALUE_BITS-1:0] val,
  output logic                  gt
);
  import mmms_pkg::*;

  localparam logic [CNT_BITS-1:0] MY_IDX = CNT_BITS'(IDX);

  logic occupied;
  logic at_end;

  assign occupied = MY_IDX < count;
  assign at_end   = MY_IDX == count;
  assign gt       = occupied && (val > din);

  always_ff @(posedge clk) begin
    if (ctl.insert && (gt || at_end)) begin
      val <= left_gt ? left_val : din;
    end else if (ctl.shift) begin
      val <= right_val;
    end
  end

endmodule

@@ hw/rtl/mmms_div.sv @@
// Restoring divider, one quotient bit per cycle.
module mmms_div #(
  parameter int DW = 31,
  parameter int CW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);
  import mmms_pkg::*;

  localparam int SW = $clog2(DW + 1);

  logic [CW-1:0] rem;
  logic [CW-1:0] dvs;
  logic [SW-1:0] steps;
  logic [CW:0]   rem_sh;
  logic [CW:0]   diff;
  logic          ge;

  assign rem_sh = {rem, quotient[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= SW'(DW);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == SW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DW-2:0], ge};
      rem      <= ge ? diff[CW-1:0] : rem_sh[CW-1:0];
    end
  end

endmodule

@@ hw/rtl/mean_median_mode_stats_unit.sv @@
// Top level of the mean / median / mode statistics unit.
// Samples stream in one per cycle while the unit is loading and are inserted
// into a row of MAX_COUNT cells kept in ascending order, so loading runs at
// one sample per clock. The request flagged with tlast closes the set: the
// row is then shifted out through the head cell once to find the median pair
// and the longest run, while a restoring divider forms the quotient
// sum*2^MEAN_FRAC_BITS/count one bit per cycle. Once the walk and the divide
// are both done, the result is registered and waits in an output register;
// loading of the next set resumes as soon as the result is registered.
// Samples arriving with the row full are discarded and reported in the
// dropped flag.
module mean_median_mode_stats_unit #(
  parameter int MAX_COUNT      = 128,
  parameter int VALUE_BITS     = 16,
  parameter int MEAN_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] value
  input  logic [mmms_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] sample_count, [31:8] mean_q8, [48:32] median_x2,
  // [64:49] mode_value, [65] mode_found, [66] dropped, [71:67] zero
  output logic [mmms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import mmms_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_COUNT + 1);
  localparam int SUM_BITS = VALUE_BITS + $clog2(MAX_COUNT);
  localparam int DW       = SUM_BITS + MEAN_FRAC_BITS;

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic                  state;
  logic [CNT_BITS-1:0]   count;
  logic [SUM_BITS-1:0]   sum;
  logic                  overflow;

  logic [VALUE_BITS-1:0] din;
  logic                  accept;
  logic                  room;
  logic [CNT_BITS-1:0]   count_next;
  logic [SUM_BITS-1:0]   sum_next;

  logic [CNT_BITS-1:0]   walk_k;
  logic                  walk_done;
  logic [CNT_BITS-1:0]   half;
  logic [VALUE_BITS-1:0] prev;
  logic [CNT_BITS-1:0]   run;
  logic [CNT_BITS-1:0]   best;
  logic [CNT_BITS-1:0]   run_next;
  logic [VALUE_BITS-1:0] mode;
  logic [VALUE_BITS-1:0] med_lo;
  logic [VALUE_BITS-1:0] med_hi;
  logic [VALUE_BITS:0]   median;
  logic                  finish;

  logic                  div_start;
  logic                  div_busy;
  logic [DW-1:0]         div_quo;

  mmms_cell_ctl_t        cell_ctl;
  logic [VALUE_BITS-1:0] cell_val [MAX_COUNT];
  logic                  cell_gt  [MAX_COUNT];
  logic [VALUE_BITS-1:0] head;

  assign din           = VALUE_BITS'(s_axis_tdata[IN_VALUE_W-1:0]);
  assign s_axis_tready = state == ST_LOAD;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign room          = count < CNT_BITS'(MAX_COUNT);
  assign count_next    = room ? count + 1'b1 : count;
  assign sum_next      = room ? sum + SUM_BITS'(din) : sum;

  assign cell_ctl.insert = accept && room;
  assign cell_ctl.shift  = (state == ST_CALC) && !walk_done;
  assign head            = cell_val[0];

  genvar i;
  generate
    for (i = 0; i < MAX_COUNT; i++) begin : g_cell
      logic [VALUE_BITS-1:0] lv;
      logic                  lg;
      logic [VALUE_BITS-1:0] rv;
      if (i == 0) begin : g_first
        assign lv = '0;
        assign lg = 1'b0;
      end else begin : g_mid
        assign lv = cell_val[i-1];
        assign lg = cell_gt[i-1];
      end
      if (i == MAX_COUNT - 1) begin : g_last
        assign rv = cell_val[i];
      end else begin : g_inner
        assign rv = cell_val[i+1];
      end
      mmms_cell #(
        .VALUE_BITS(VALUE_BITS),
        .CNT_BITS  (CNT_BITS),
        .IDX       (i)
      ) u_cell (
        .clk      (clk),
        .ctl      (cell_ctl),
        .din      (din),
        .count    (count),
        .left_val (lv),
        .left_gt  (lg),
        .right_val(rv),
        .val      (cell_val[i]),
        .gt       (cell_gt[i])
      );
    end
  endgenerate

  assign div_start = accept && s_axis_tlast;

  mmms_div #(
    .DW(DW),
    .CW(CNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(DW'(sum_next) << MEAN_FRAC_BITS),
    .divisor (count_next),
    .busy    (div_busy),
    .quotient(div_quo)
  );

  assign walk_done = walk_k == count;
  assign half      = count >> 1;
  assign run_next  = (head == prev) ? run + 1'b1 : CNT_BITS'(1);
  assign median    = count[0] ? {med_hi, 1'b0}
                              : {1'b0, med_lo} + {1'b0, med_hi};
  assign finish    = (state == ST_CALC) && walk_done && !div_busy
                     && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      sum      <= '0;
      overflow <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            count    <= count_next;
            sum      <= sum_next;
            overflow <= overflow || !room;
            if (s_axis_tlast) begin
              state <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          if (finish) begin
            count    <= '0;
            sum      <= '0;
            overflow <= 1'b0;
            state    <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // statistics walk over the row as it drains through the head cell
  always_ff @(posedge clk) begin
    if (div_start) begin
      walk_k <= '0;
    end else if (cell_ctl.shift) begin
      walk_k <= walk_k + 1'b1;
      prev   <= head;
      if (walk_k == '0) begin
        run  <= CNT_BITS'(1);
        best <= CNT_BITS'(1);
        mode <= head;
      end else begin
        run <= run_next;
        if (run_next > best) begin
          best <= run_next;
          mode <= head;
        end
      end
      if (walk_k == half - 1'b1) begin
        med_lo <= head;
      end
      if (walk_k == half) begin
        med_hi <= head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_axis_tdata <= OUT_TDATA_W'({overflow,
                                    best > CNT_BITS'(1),
                                    MODE_W'(mode),
                                    MEDIAN_W'(median),
                                    MEAN_W'(div_quo),
                                    COUNT_W'(count)});
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(MAX_COUNT))
    else $error("sample count above capacity");

  a_last_starts_calc: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == ST_CALC) && div_busy)
    else $error("closing request did not start the divider");

  a_result_after_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_CALC) && $past(walk_done)
                             && !$past(div_busy))
    else $error("result raised before walk and divide completed");

  a_no_load_during_calc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) |-> !s_axis_tready && !cell_ctl.insert)
    else $error("insert while the row is draining");
`endif

endmodule

@@ tb/sv/mean_median_mode_stats_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the mean/median/mode statistics unit, sample sets in, one result each.
module mean_median_mode_stats_unit_tb;
  import mmms_pkg::*;

  localparam int STORE_DEPTH  = 128;
  localparam int FRAC_BITS    = 8;
  localparam int STALL_LIMIT  = 6000;
  localparam int DRAIN_CYCLES = 200;
  localparam int DIR_SETS     = 7;
  localparam int DIR_REQS     = 21;
  localparam int SMALL_SETS   = 32;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic                  last;
    logic                  hold;
  } sample_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  sample_count;
    logic [MEAN_W-1:0]   mean_q8;
    logic [MEDIAN_W-1:0] median_x2;
    logic [MODE_W-1:0]   mode_value;
    logic                mode_found;
    logic                dropped;
  } set_stats_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  wire  [OUT_TDATA_W-1:0] m_axis_tdata;

  sample_req_t pending_reqs[$];
  set_stats_t  expected_stats[$];

  logic [IN_VALUE_W-1:0] kept_values[STORE_DEPTH];
  int                    kept_count = 0;
  longint                kept_sum = 0;
  bit                    kept_overflow = 1'b0;

  int total_reqs = 1;
  int accepted_reqs = 0;
  int idle_phase = 0;
  int errors = 0;
  int quiet_cycles = 0;

  int                    dir_sizes[DIR_SETS] = '{1, 1, 3, 4, 6, 4, 2};
  logic [IN_VALUE_W-1:0] dir_vals[DIR_REQS] = '{
    16'h0000,
    16'hFFFF,
    16'd5, 16'd3, 16'd9,
    16'd7, 16'd7, 16'd2, 16'd2,
    16'd100, 16'd1, 16'd100, 16'd50, 16'd1, 16'd100,
    16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555,
    16'h8000, 16'h7FFF
  };

  mean_median_mode_stats_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void push_req(logic [IN_VALUE_W-1:0] value, logic last, logic hold);
    sample_req_t r;
    r.value = value;
    r.last  = last;
    r.hold  = hold;
    pending_reqs.push_back(r);
  endfunction

  // Sorted insert of one accepted sample; closes the set on last.
  function automatic void absorb_sample(logic [IN_VALUE_W-1:0] v, logic last);
    int         pos;
    int         run;
    int         best;
    set_stats_t r;
    if (kept_count < STORE_DEPTH) begin
      pos = kept_count;
      while (pos > 0 && kept_values[pos-1] > v) begin
        kept_values[pos] = kept_values[pos-1];
        pos--;
      end
      kept_values[pos] = v;
      kept_count++;
      kept_sum += v;
    end else begin
      kept_overflow = 1'b1;
    end
    if (last) begin
      r.sample_count = COUNT_W'(kept_count);
      r.mean_q8      = MEAN_W'((kept_sum << FRAC_BITS) / kept_count);
      if (kept_count % 2 == 1)
        r.median_x2 = MEDIAN_W'(kept_values[kept_count/2] * 2);
      else
        r.median_x2 = MEDIAN_W'(kept_values[kept_count/2-1])
                      + MEDIAN_W'(kept_values[kept_count/2]);
      r.mode_value = kept_values[0];
      best = 1;
      run  = 1;
      for (int i = 1; i < kept_count; i++) begin
        if (kept_values[i] == kept_values[i-1])
          run++;
        else
          run = 1;
        if (run > best) begin
          best = run;
          r.mode_value = kept_values[i];
        end
      end
      r.mode_found = (best > 1);
      r.dropped    = kept_overflow;
      expected_stats.push_back(r);
      kept_count    = 0;
      kept_sum      = 0;
      kept_overflow = 1'b0;
    end
  endfunction

  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // driver
  always @(posedge clk) begin : drive_blk
    sample_req_t           req;
    logic                  nxt_valid;
    logic [IN_VALUE_W-1:0] nxt_data;
    logic                  nxt_last;
    int                    idle_pct;
    int                    done_reqs;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_data  = s_axis_tdata;
      nxt_last  = s_axis_tlast;
      done_reqs = accepted_reqs;
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_sample(s_axis_tdata[IN_VALUE_W-1:0], s_axis_tlast);
        done_reqs++;
        nxt_valid = 1'b0;
      end
      idle_pct = (idle_phase == 1) ? 73 : (idle_phase == 3) ? 31 : 0;
      if (!nxt_valid && pending_reqs.size() > 0
          && !(pending_reqs[0].hold && expected_stats.size() > 0)
          && $urandom_range(0, 99) >= idle_pct) begin
        req       = pending_reqs.pop_front();
        nxt_valid = 1'b1;
        nxt_data  = req.value;
        nxt_last  = req.last;
      end
      accepted_reqs <= done_reqs;
      idle_phase    <= done_reqs * 5 / total_reqs;
      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
      s_axis_tlast  <= nxt_last;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin : sink_blk
    int stall_pct;
    stall_pct = (idle_phase == 2) ? 73 : (idle_phase == 3) ? 31 : 0;
    if (rst)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // monitor
  always @(posedge clk) begin : check_blk
    set_stats_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_stats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want = expected_stats.pop_front();
        check_field("sample_count", longint'(want.sample_count),
                    longint'(m_axis_tdata[7:0]));
        check_field("mean_q8", longint'(want.mean_q8), longint'(m_axis_tdata[31:8]));
        check_field("median_x2", longint'(want.median_x2), longint'(m_axis_tdata[48:32]));
        check_field("mode_value", longint'(want.mode_value), longint'(m_axis_tdata[64:49]));
        check_field("mode_found", longint'(want.mode_found), longint'(m_axis_tdata[65]));
        check_field("dropped", longint'(want.dropped), longint'(m_axis_tdata[66]));
        check_field("padding", 0, longint'(m_axis_tdata[71:67]));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stim_blk
    int                    idx;
    int                    set_len;
    bit                    pooled;
    logic [IN_VALUE_W-1:0] base;
    logic [IN_VALUE_W-1:0] v;

    idx = 0;
    for (int s = 0; s < DIR_SETS; s++) begin
      for (int k = 0; k < dir_sizes[s]; k++) begin
        push_req(dir_vals[idx], k == dir_sizes[s] - 1, 1'b0);
        idx++;
      end
    end

    for (int s = 0; s < SMALL_SETS; s++) begin
      // full store: all-max set runs two past capacity, last one dropped too
      if (s == 8) begin
        for (int k = 0; k < STORE_DEPTH + 2; k++)
          push_req(16'hFFFF, k == STORE_DEPTH + 1, 1'b0);
      end
      // exactly full, heavy repeats
      if (s == 22) begin
        base = IN_VALUE_W'($urandom_range(0, 65535));
        for (int k = 0; k < STORE_DEPTH; k++)
          push_req(base + 16'($urandom_range(0, 15)), k == STORE_DEPTH - 1, 1'b0);
      end
      set_len = $urandom_range(1, 10);
      pooled  = 1'($urandom_range(0, 1));
      base    = IN_VALUE_W'($urandom_range(0, 65535));
      for (int k = 0; k < set_len; k++) begin
        v = pooled ? base + 16'($urandom_range(0, 3)) : 16'($urandom_range(0, 65535));
        push_req(v, k == set_len - 1, k == 0 && (s == 0 || s == 30));
      end
    end
    total_reqs = pending_reqs.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_stats.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_stats.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mmms_pkg.sv
hw/rtl/mmms_cell.sv
hw/rtl/mmms_div.sv
hw/rtl/mean_median_mode_stats_unit.sv
tb/sv/mean_median_mode_stats_unit_tb.sv
